/* sv/fht_pkg.sv */
// ----------------------------------------------------------------------------
// fht_pkg: shared types and constants of the flow heavy-hitter table
// Payload structs, register indexes and protocol constants.
// ----------------------------------------------------------------------------
package fht_pkg;

  localparam int unsigned EntriesPerTable = 512;
  localparam int unsigned CountBits       = 48;

  localparam logic [15:0] EthIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [15:0] MinIpLen  = 16'd34;
  localparam logic [15:0] MinUdpLen = 16'd42;
  localparam logic [15:0] MinTcpLen = 16'd54;

  localparam logic [31:0] ThresholdReset = 32'd1024;
  localparam logic [31:0] IpMaskReset    = 32'hFFFF_FFF0;

  localparam int unsigned KeyBits = 104;

  typedef enum logic [7:0] {
    REG_BYTE_THRESHOLD = 8'd0,
    REG_SOURCE_IP_MASK = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] ethertype;
    logic [7:0]  ip_protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        syn_flag;
    logic        tcp_fin;
    logic [15:0] frame_len;
  } in_item_t;

  typedef struct packed {
    logic        verdict;
    logic        table_hit;
    logic        heavy;
    logic [47:0] flow_bytes;
    logic        inserted;
    logic        removed;
    logic        insert_failed;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  proto;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_key_t;

  typedef struct packed {
    logic        drop;
    logic        is_tcp;
    logic        syn;
    logic        fin;
    flow_key_t   key;
    logic [15:0] len;
  } cls_item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_status_t;

endpackage

/* sv/flow_heavy_hitter_table_top.sv */
// ----------------------------------------------------------------------------
// flow_heavy_hitter_table_top: per-flow byte counter with heavy-hitter flag
// Classifies packet summaries, tracks flows in an associative table and
// reports a verdict, hit/insert/remove flags and the running byte count.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | sink      | in_valid_i/stall_o | in_data_i  (in_item_t)
//  out     | source    | out_valid_o/stall_i| out_data_o (out_item_t)
//  cfg     | sink      | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
//
//  For a valid packet the engine walks every table slot through the single
//  read port of the flow RAM. Dropped packets skip the table scan.
//  After reset a clearing pass zeroes every slot of the RAM; input
//  transfers are held off meanwhile, config writes are taken.
//  The two-entry queue keeps accepting until full while the engine works or
//  the output register is stalled.
// ----------------------------------------------------------------------------
module flow_heavy_hitter_table_top #(
  parameter int unsigned ENTRIES_PER_TABLE = fht_pkg::EntriesPerTable,
  parameter int unsigned COUNT_BITS        = fht_pkg::CountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fht_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fht_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import fht_pkg::*;

  logic [31:0]  threshold_q, threshold_d;
  logic [31:0]  ip_mask_q, ip_mask_d;
  logic         push, q_full, pop, pop_valid;
  cls_item_t    push_item, pop_item;
  back_status_t status;

  // Config: always ready; unknown indexes drop silently.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    threshold_d = threshold_q;
    ip_mask_d   = ip_mask_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BYTE_THRESHOLD: threshold_d = cfg_data_i;
        REG_SOURCE_IP_MASK: ip_mask_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdReset;
      ip_mask_q   <= IpMaskReset;
    end else begin
      threshold_q <= threshold_d;
      ip_mask_q   <= ip_mask_d;
    end
  end

  // Front: classify and key; hold input while the queue is full or RAM clears.
  fht_front u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .ip_mask_i (ip_mask_q),
    .hold_i    (q_full || status.clearing),
    .in_stall_o(in_stall_o),
    .push_o    (push),
    .item_o    (push_item)
  );

  fht_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_item),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_valid_o(pop_valid),
    .pop_data_o (pop_item)
  );

  // Back: table scan, update and result register.
  fht_back #(
    .EntriesPerTable(ENTRIES_PER_TABLE),
    .CountBits      (COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .threshold_i(threshold_q),
    .pop_valid_i(pop_valid),
    .pop_data_i (pop_item),
    .pop_o      (pop),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* sv/fht_ram.sv */
// ----------------------------------------------------------------------------
// fht_ram: generic single-write, single-read RAM
// Read data is registered.
// ----------------------------------------------------------------------------
module fht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fht_front.sv */
// ----------------------------------------------------------------------------
// fht_front: packet classifier
// Decide drop, build the masked flow key and push into the queue.
// ----------------------------------------------------------------------------
module fht_front (
  input  logic               in_valid_i,
  input  fht_pkg::in_item_t  in_data_i,
  input  logic [31:0]        ip_mask_i,
  input  logic               hold_i,
  output logic               in_stall_o,
  output logic               push_o,
  output fht_pkg::cls_item_t item_o
);
  import fht_pkg::*;

  logic is_tcp, is_udp, drop;

  always_comb begin
    is_tcp = in_data_i.ip_protocol == ProtoTcp;
    is_udp = in_data_i.ip_protocol == ProtoUdp;
    drop   = (in_data_i.ethertype != EthIpv4) || (in_data_i.frame_len < MinIpLen) ||
             (!is_tcp && !is_udp) ||
             (is_udp && (in_data_i.frame_len < MinUdpLen)) ||
             (is_tcp && (in_data_i.frame_len < MinTcpLen));
  end

  always_comb begin
    item_o.drop      = drop;
    item_o.is_tcp    = is_tcp;
    item_o.syn       = in_data_i.syn_flag;
    item_o.fin       = in_data_i.tcp_fin;
    item_o.key.proto = in_data_i.ip_protocol;
    item_o.key.sip   = in_data_i.source_ip & ip_mask_i;
    item_o.key.dip   = in_data_i.dest_ip;
    item_o.key.sport = in_data_i.source_port;
    item_o.key.dport = in_data_i.dest_port;
    item_o.len       = in_data_i.frame_len;
  end

  assign in_stall_o = hold_i;
  assign push_o     = in_valid_i && !hold_i;

endmodule

/* sv/fht_queue.sv */
// ----------------------------------------------------------------------------
// fht_queue: two-entry queue between classifier and table engine
// Decouple the two sides so each can stall on its own.
// ----------------------------------------------------------------------------
module fht_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fht_pkg::cls_item_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               pop_valid_o,
  output fht_pkg::cls_item_t pop_data_o
);
  import fht_pkg::*;

  cls_item_t   slot_q [2];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o      = count_q == 2'd2;
  assign pop_valid_o = count_q != 2'd0;
  assign pop_data_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q ^ push_i;
    rptr_d  = rptr_q ^ pop_i;
    count_d = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/fht_back.sv */
// ----------------------------------------------------------------------------
// fht_back: table engine
// Scan the flow RAM, update, insert or remove the entry and register the result.
// ----------------------------------------------------------------------------
module fht_back #(
  parameter int unsigned EntriesPerTable = fht_pkg::EntriesPerTable,
  parameter int unsigned CountBits       = fht_pkg::CountBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          threshold_i,
  input  logic                 pop_valid_i,
  input  fht_pkg::cls_item_t   pop_data_i,
  output logic                 pop_o,
  output fht_pkg::back_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fht_pkg::out_item_t   out_data_o
);
  import fht_pkg::*;

  localparam int unsigned Slots = 2 * EntriesPerTable;
  localparam int unsigned Aw    = $clog2(Slots);
  localparam int unsigned Ew    = 1 + KeyBits + CountBits;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [Aw:0]         cnt_q, cnt_d;
  logic                chk_q, chk_d;
  logic [Aw-1:0]       chk_idx_q, chk_idx_d;
  cls_item_t           item_q, item_d;
  logic                found_q, found_d, free_q, free_d;
  logic [Aw-1:0]       match_idx_q, match_idx_d, free_idx_q, free_idx_d;
  logic [CountBits-1:0] match_bytes_q, match_bytes_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                we;
  logic [Aw-1:0]       waddr;
  logic [Ew-1:0]       wdata, rdata;
  logic                r_valid;
  flow_key_t           r_key;
  logic [CountBits-1:0] r_bytes;
  logic [CountBits:0]  sum;
  logic [CountBits-1:0] len_ext, sat_sum, bytes;
  logic [63:0]         bytes64;
  logic                out_free, want_ins;

  fht_ram #(.Width(Ew), .Depth(Slots)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(cnt_q[Aw-1:0]),
    .rdata_o(rdata)
  );

  assign r_valid = rdata[Ew-1];
  assign r_key   = rdata[Ew-2:CountBits];
  assign r_bytes = rdata[CountBits-1:0];

  always_comb begin
    len_ext  = CountBits'(item_q.len);
    sum      = {1'b0, match_bytes_q} + {1'b0, len_ext};
    sat_sum  = sum[CountBits] ? CountMax : sum[CountBits-1:0];
    bytes    = found_q ? sat_sum : len_ext;
    bytes64  = 64'(bytes);
    out_free = !out_valid_q || !out_stall_i;
    want_ins = !item_q.is_tcp || item_q.syn;
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    chk_d         = 1'b0;
    chk_idx_d     = cnt_q[Aw-1:0];
    item_d        = item_q;
    found_d       = found_q;
    free_d        = free_q;
    match_idx_d   = match_idx_q;
    free_idx_d    = free_idx_q;
    match_bytes_d = match_bytes_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_d         = out_q;
    pop_o         = 1'b0;
    we            = 1'b0;
    waddr         = cnt_q[Aw-1:0];
    wdata         = '0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (Aw+1)'(Slots - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          item_d  = pop_data_i;
          cnt_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
          state_d = pop_data_i.drop ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read a cycle, check the data of the previous one
        if (!cnt_q[Aw]) begin
          chk_d = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        if (chk_q) begin
          if (r_valid && (r_key == item_q.key) && !found_q) begin
            found_d       = 1'b1;
            match_idx_d   = chk_idx_q;
            match_bytes_d = r_bytes;
          end
          if (!r_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
        end
        if (cnt_q[Aw] && !chk_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          if (!item_q.drop) begin
            out_d.verdict    = 1'b1;
            out_d.table_hit  = found_q;
            out_d.heavy      = bytes64 >= 64'(threshold_i);
            out_d.flow_bytes = bytes64[47:0];
            if (found_q) begin
              we    = 1'b1;
              waddr = match_idx_q;
              wdata = {!(item_q.is_tcp && item_q.fin), item_q.key, sat_sum};
              out_d.removed = item_q.is_tcp && item_q.fin;
            end else if (want_ins) begin
              if (free_q) begin
                we    = 1'b1;
                waddr = free_idx_q;
                wdata = {1'b1, item_q.key, len_ext};
                out_d.inserted = 1'b1;
              end else begin
                out_d.insert_failed = 1'b1;
              end
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q     <= chk_idx_d;
    item_q        <= item_d;
    found_q       <= found_d;
    free_q        <= free_d;
    match_idx_q   <= match_idx_d;
    free_idx_q    <= free_idx_d;
    match_bytes_q <= match_bytes_d;
    out_q         <= out_d;
  end

  assign status_o.clearing = state_q == ST_CLEAR;
  assign status_o.busy     = state_q != ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule
